// ===== rtl/core/srh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_pkg
// Shared types and constants for the rolling hash core (modulus 2^61-1).
// ----------------------------------------------------------------------------
package srh_pkg;

    localparam int unsigned HASH_W = 61;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LIMB_W = 31;
    localparam int unsigned PROD_W = 2 * LIMB_W;

    localparam logic [HASH_W-1:0] HASH_MOD  = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] BASE_RST  = 61'd131;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_HASH   = 2'd2,
        MODE_CMP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_LEN  = 2'd1,
        RD_LOW  = 2'd2,
        RD_HIGH = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO   = 3'd0,
        RES_RANGE  = 3'd1,
        RES_FULL   = 3'd2,
        RES_APPEND = 3'd3,
        RES_HASH   = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     clr_len;
        logic     inc_len;
        logic     wr_tables;
        rd_sel_t  rd_sel;
        logic     ld_ops;
        logic     ld_add;
        logic     mul_start;
        logic     ld_app1;
        logic     save_h1;
        logic     set_res;
        res_sel_t res_sel;
        logic     out_load;
        logic     phase;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  range_ok;
        logic  mul_done;
    } stat_t;

    // canonical residue of a 64-bit value
    function automatic logic [HASH_W-1:0] fold64(input logic [63:0] x);
        logic [63:0] s;
        s = {61'd0, x[63:61]} + {3'd0, x[60:0]};
        if (s >= {3'd0, HASH_MOD})
            s = s - {3'd0, HASH_MOD};
        return s[HASH_W-1:0];
    endfunction

endpackage

// ===== rtl/core/substring_rolling_hash_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_rolling_hash_engine_core
// Polynomial rolling hash modulo 2^61-1 over a loaded byte string.
// ----------------------------------------------------------------------------
// channel  | handshake           | word
// input    | in_valid / in_stall | mode, char_byte, first_*, second_*
// output   | out_valid/out_stall | hash_value, ranges_equal, string_length, status
// config   | cfg_wr_en           | cfg_wr_data (hash_base)
//
// One word at a time. Append takes two modular products. Each modular product
// runs on the shared 31x31 multiplier; table reads are registered.
// The output register lets the next word in while a result waits.
// No clearing pass after reset: entry zero of each table is fixed logic.
// ----------------------------------------------------------------------------
module substring_rolling_hash_engine_core
    import srh_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned LEN_W   = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [HASH_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [BYTE_W-1:0] char_byte,
    input  logic [LEN_W-1:0]  first_start,
    input  logic [LEN_W-1:0]  first_end,
    input  logic [LEN_W-1:0]  second_start,
    input  logic [LEN_W-1:0]  second_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HASH_W-1:0] hash_value,
    output logic              ranges_equal,
    output logic [LEN_W-1:0]  string_length,
    output logic [1:0]        status
);

    cmd_t  cmd;
    stat_t stat;

    srh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    srh_datapath #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mode          (mode),
        .char_byte     (char_byte),
        .first_start   (first_start),
        .first_end     (first_end),
        .second_start  (second_start),
        .second_end    (second_end),
        .hash_value    (hash_value),
        .ranges_equal  (ranges_equal),
        .string_length (string_length),
        .status        (status)
    );

endmodule

// ===== rtl/core/srh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srh_ram #(
    parameter int unsigned WIDTH = 61,
    parameter int unsigned DEPTH = 4097
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/srh_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_mulmod
// Product modulo 2^61-1, four 31x31 partial products, one per cycle.
// ----------------------------------------------------------------------------
module srh_mulmod
    import srh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] op_a,
    input  logic [HASH_W-1:0] op_b,
    output logic              done,
    output logic [HASH_W-1:0] result
);

    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              pv_reg;
    logic              done_reg;
    logic [1:0]        kind_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [HASH_W-1:0] acc_reg;

    logic [LIMB_W-1:0] limb_a;
    logic [LIMB_W-1:0] limb_b;
    logic [63:0]       term;

    assign limb_a = step_reg[1] ? {1'b0, op_a[HASH_W-1:LIMB_W]} : op_a[LIMB_W-1:0];
    assign limb_b = step_reg[0] ? {1'b0, op_b[HASH_W-1:LIMB_W]} : op_b[LIMB_W-1:0];

    // weight 2^0, 2^31 or 2^62 folded with 2^61 = 1
    always_comb
    begin
        case (kind_reg)
            2'd0:    term = {2'd0, prod_reg};
            2'd3:    term = {1'b0, prod_reg, 1'b0};
            default: term = {32'd0, prod_reg[PROD_W-1:30]}
                          + {3'd0, prod_reg[29:0], 31'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 3'd4);
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                pv_reg   <= (step_reg != 3'd4);
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd4)
            begin
                prod_reg <= limb_a * limb_b;
                kind_reg <= (step_reg == 3'd0) ? 2'd0 :
                            (step_reg == 3'd3) ? 2'd3 : 2'd1;
            end
            if (pv_reg)
            begin
                acc_reg <= fold64({3'd0, acc_reg} + term);
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/core/srh_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_datapath
// Tables, length counter, operand registers, multiplier and result registers.
// ----------------------------------------------------------------------------
module srh_datapath
    import srh_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned LEN_W   = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              cfg_wr_en,
    input  logic [HASH_W-1:0] cfg_wr_data,
    input  logic [1:0]        mode,
    input  logic [BYTE_W-1:0] char_byte,
    input  logic [LEN_W-1:0]  first_start,
    input  logic [LEN_W-1:0]  first_end,
    input  logic [LEN_W-1:0]  second_start,
    input  logic [LEN_W-1:0]  second_end,
    output logic [HASH_W-1:0] hash_value,
    output logic              ranges_equal,
    output logic [LEN_W-1:0]  string_length,
    output logic [1:0]        status
);

    localparam int unsigned DEPTH = MAX_LEN + 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    logic [HASH_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    mode_t             mode_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  l1_reg, r1_reg, l2_reg, r2_reg;
    logic [HASH_W-1:0] op_a_reg, op_b_reg, add_reg, pow_save_reg;
    logic [HASH_W-1:0] new_pre_reg, h1_reg;
    logic              pre_zero_reg, pow_zero_reg;
    logic [HASH_W-1:0] res_hv_reg;
    logic              res_eq_reg;
    logic [1:0]        res_st_reg;
    logic [HASH_W-1:0] out_hv_reg;
    logic              out_eq_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [1:0]        out_st_reg;

    logic [LEN_W-1:0]  l_sel, r_sel, pre_raddr, pow_raddr, waddr;
    logic [HASH_W-1:0] pre_ram, pow_ram, pre_rd, pow_rd;
    logic [HASH_W-1:0] hv_tmp, mul_res;
    logic              mul_done, ok1, ok2;

    assign l_sel = cmd.phase ? l2_reg : l1_reg;
    assign r_sel = cmd.phase ? r2_reg : r1_reg;
    assign waddr = len_reg + LEN_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_LEN:
            begin
                pre_raddr = len_reg;
                pow_raddr = len_reg;
            end
            RD_LOW:
            begin
                pre_raddr = l_sel;
                pow_raddr = r_sel - l_sel;
            end
            RD_HIGH:
            begin
                pre_raddr = r_sel;
                pow_raddr = '0;
            end
            default:
            begin
                pre_raddr = '0;
                pow_raddr = '0;
            end
        endcase
    end

    srh_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_pre_ram (
        .clk   (clk),
        .we    (cmd.wr_tables),
        .waddr (waddr),
        .wdata (new_pre_reg),
        .raddr (pre_raddr),
        .rdata (pre_ram)
    );

    srh_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_pow_ram (
        .clk   (clk),
        .we    (cmd.wr_tables),
        .waddr (waddr),
        .wdata (mul_res),
        .raddr (pow_raddr),
        .rdata (pow_ram)
    );

    srh_mulmod u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (op_a_reg),
        .op_b   (op_b_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    // entry zero is fixed and never written
    assign pre_rd = pre_zero_reg ? '0 : pre_ram;
    assign pow_rd = pow_zero_reg ? HASH_W'(1) : pow_ram;

    assign hv_tmp = fold64({3'd0, add_reg} + {3'd0, HASH_MOD} - {3'd0, mul_res});

    assign ok1 = (l1_reg <= r1_reg) && (r1_reg <= len_reg);
    assign ok2 = (l2_reg <= r2_reg) && (r2_reg <= len_reg);

    assign stat.mode     = mode_reg;
    assign stat.full     = (len_reg == LEN_MAX);
    assign stat.range_ok = ok1 && (ok2 || (mode_reg != MODE_CMP));
    assign stat.mul_done = mul_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RST;
            len_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.clr_len)
            begin
                len_reg <= '0;
            end
            else if (cmd.inc_len)
            begin
                len_reg <= waddr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pre_zero_reg <= (pre_raddr == '0);
        pow_zero_reg <= (pow_raddr == '0);
        if (cmd.latch_in)
        begin
            mode_reg <= mode_t'(mode);
            byte_reg <= char_byte;
            l1_reg   <= first_start;
            r1_reg   <= first_end;
            l2_reg   <= second_start;
            r2_reg   <= second_end;
        end
        if (cmd.ld_ops)
        begin
            op_a_reg     <= pre_rd;
            op_b_reg     <= (mode_reg == MODE_APPEND) ? base_reg : pow_rd;
            pow_save_reg <= pow_rd;
        end
        else if (cmd.ld_app1)
        begin
            op_a_reg <= pow_save_reg;
            op_b_reg <= base_reg;
        end
        if (cmd.ld_app1)
        begin
            new_pre_reg <= fold64({3'd0, mul_res} + {3'd0, add_reg});
        end
        if (cmd.ld_add)
        begin
            add_reg <= (mode_reg == MODE_APPEND) ? {{(HASH_W-BYTE_W){1'b0}}, byte_reg}
                                                 : pre_rd;
        end
        if (cmd.save_h1)
        begin
            h1_reg <= hv_tmp;
        end
        if (cmd.set_res)
        begin
            case (cmd.res_sel)
                RES_RANGE:
                begin
                    res_hv_reg <= '0;
                    res_eq_reg <= 1'b0;
                    res_st_reg <= ST_RANGE;
                end
                RES_FULL:
                begin
                    res_hv_reg <= '0;
                    res_eq_reg <= 1'b0;
                    res_st_reg <= ST_FULL;
                end
                RES_APPEND:
                begin
                    res_hv_reg <= new_pre_reg;
                    res_eq_reg <= 1'b0;
                    res_st_reg <= ST_OK;
                end
                RES_HASH:
                begin
                    res_hv_reg <= (mode_reg == MODE_CMP) ? h1_reg : hv_tmp;
                    res_eq_reg <= (mode_reg == MODE_CMP) && (h1_reg == hv_tmp);
                    res_st_reg <= ST_OK;
                end
                default:
                begin
                    res_hv_reg <= '0;
                    res_eq_reg <= 1'b0;
                    res_st_reg <= ST_OK;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_hv_reg  <= res_hv_reg;
            out_eq_reg  <= res_eq_reg;
            out_st_reg  <= res_st_reg;
            out_len_reg <= len_reg;
        end
    end

    assign hash_value    = out_hv_reg;
    assign ranges_equal  = out_eq_reg;
    assign string_length = out_len_reg;
    assign status        = out_st_reg;

endmodule

// ===== rtl/core/srh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_ctrl
// Sequencer: decode, table reads, multiply passes and output handshake.
// ----------------------------------------------------------------------------
module srh_ctrl
    import srh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_LOAD2  = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_REREAD = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !(out_valid_reg && out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.rd_sel     = RD_NONE;
        cmd.res_sel    = RES_ZERO;
        cmd.phase      = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                phase_next = 1'b0;
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clr_len = 1'b1;
                        cmd.set_res = 1'b1;
                        state_next  = S_DONE;
                    end
                    MODE_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_sel = RES_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_LEN;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        if (!stat.range_ok)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_sel = RES_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.phase  = 1'b0;
                            cmd.rd_sel = RD_LOW;
                            state_next = S_LOAD;
                        end
                    end
                endcase
            end
            S_LOAD:
            begin
                cmd.ld_ops = 1'b1;
                cmd.rd_sel = RD_HIGH;
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                cmd.ld_add    = 1'b1;
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    if (stat.mode == MODE_APPEND)
                    begin
                        if (!phase_reg)
                        begin
                            cmd.ld_app1   = 1'b1;
                            cmd.mul_start = 1'b1;
                            phase_next    = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_tables = 1'b1;
                            cmd.inc_len   = 1'b1;
                            state_next    = S_DONE;
                        end
                    end
                    else if ((stat.mode == MODE_CMP) && !phase_reg)
                    begin
                        cmd.save_h1 = 1'b1;
                        phase_next  = 1'b1;
                        state_next  = S_REREAD;
                    end
                    else
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_HASH;
                        state_next  = S_DONE;
                    end
                end
            end
            S_REREAD:
            begin
                cmd.rd_sel = RD_LOW;
                state_next = S_LOAD;
            end
            S_DONE:
            begin
                if (stat.mode == MODE_APPEND && phase_reg)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_APPEND;
                    phase_next  = 1'b0;
                end
                else if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/srh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srh_checker
// Port-level checks on the rolling hash core, bound to the top level.
// ----------------------------------------------------------------------------
module srh_checker
    import srh_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned LEN_W   = 13
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [HASH_W-1:0] hash_value,
    input logic              ranges_equal,
    input logic [LEN_W-1:0]  string_length,
    input logic [1:0]        status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");

    a_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ranges_equal |-> status == ST_OK)
        else $error("match flagged on failed word");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> hash_value == '0)
        else $error("hash on failed word");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> string_length <= LEN_W'(MAX_LEN))
        else $error("length beyond capacity");

endmodule

bind substring_rolling_hash_engine_core srh_checker #(
    .MAX_LEN(MAX_LEN),
    .LEN_W  (LEN_W)
) u_srh_checker (.*);

// ===== test/substring_rolling_hash_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_rolling_hash_engine_core_tb
// Self-checking bench for the rolling hash core.
// A scoreboard class keeps its own prefix-hash and power tables. It predicts
// each result from the accepted input word and compares the outputs field by
// field. Directed words cover clear, append, range hash, compare, bad ranges
// and field extremes. Random strings follow under several bases, with one
// long output hold. Both sides idle at random.
// ----------------------------------------------------------------------------
module substring_rolling_hash_engine_core_tb;
    import srh_pkg::*;

    localparam int CAP    = 4096;
    localparam int LW     = 13;
    localparam int LIMIT  = 1500000;

    typedef struct {
        logic [HASH_W-1:0] hv;
        logic              eq;
        logic [LW-1:0]     len;
        logic [1:0]        st;
    } hash_result_t;

    class hash_scoreboard;
        logic [HASH_W-1:0] prefix_tbl [0:CAP];
        logic [HASH_W-1:0] power_tbl [0:CAP];
        logic [LW-1:0]     cur_len;
        logic [HASH_W-1:0] base;
        hash_result_t      pending[$];
        int                errors;
        int                checked;
        int                n_full;
        int                n_bad;
        int                n_equal;

        function new();
            prefix_tbl[0] = '0;
            power_tbl[0] = HASH_W'(1);
            cur_len = '0;
            base = BASE_RST;
            errors = 0;
            checked = 0;
            n_full = 0;
            n_bad = 0;
            n_equal = 0;
        endfunction

        function logic [HASH_W-1:0] mod_mul(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
            logic [121:0] p;
            logic [62:0]  s;
            p = a * b;
            s = p[121:61] + p[60:0];
            while (s >= HASH_MOD)
                s = s - HASH_MOD;
            return s[HASH_W-1:0];
        endfunction

        function logic [HASH_W-1:0] mod_sub(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
            logic [62:0] s;
            s = a + HASH_MOD - b;
            while (s >= HASH_MOD)
                s = s - HASH_MOD;
            return s[HASH_W-1:0];
        endfunction

        function logic [HASH_W-1:0] span_hash(int l, int r);
            return mod_sub(prefix_tbl[r], mod_mul(prefix_tbl[l], power_tbl[r - l]));
        endfunction

        function bit span_ok(int l, int r);
            return l <= r && r <= cur_len;
        endfunction

        function void note_word(mode_t m, logic [7:0] b, int l1, int r1, int l2, int r2);
            hash_result_t e;
            logic [62:0]  s;
            e.hv = '0;
            e.eq = 1'b0;
            e.st = ST_OK;
            case (m)
                MODE_CLEAR: cur_len = '0;
                MODE_APPEND:
                begin
                    if (cur_len >= CAP)
                    begin
                        e.st = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        s = mod_mul(prefix_tbl[cur_len], base) + b;
                        while (s >= HASH_MOD)
                            s = s - HASH_MOD;
                        prefix_tbl[cur_len + 1] = s[HASH_W-1:0];
                        power_tbl[cur_len + 1] = mod_mul(power_tbl[cur_len], base);
                        cur_len = cur_len + 1'b1;
                        e.hv = prefix_tbl[cur_len];
                    end
                end
                MODE_HASH:
                begin
                    if (span_ok(l1, r1))
                        e.hv = span_hash(l1, r1);
                    else
                    begin
                        e.st = ST_RANGE;
                        n_bad++;
                    end
                end
                default:
                begin
                    if (span_ok(l1, r1) && span_ok(l2, r2))
                    begin
                        e.hv = span_hash(l1, r1);
                        e.eq = (e.hv == span_hash(l2, r2));
                        if (e.eq)
                            n_equal++;
                    end
                    else
                    begin
                        e.st = ST_RANGE;
                        n_bad++;
                    end
                end
            endcase
            e.len = cur_len;
            pending = {pending, e};
        endfunction

        function void check_word(logic [HASH_W-1:0] hv, logic eq, logic [LW-1:0] len,
                                 logic [1:0] st);
            hash_result_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (hv !== e.hv)
            begin
                $error("hash_value expected %0h got %0h", e.hv, hv);
                errors++;
            end
            if (eq !== e.eq)
            begin
                $error("ranges_equal expected %0b got %0b", e.eq, eq);
                errors++;
            end
            if (len !== e.len)
            begin
                $error("string_length expected %0d got %0d", e.len, len);
                errors++;
            end
            if (st !== e.st)
            begin
                $error("status expected %0d got %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [HASH_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        mode = MODE_CLEAR;
    logic [7:0]        char_byte = '0;
    logic [LW-1:0]     first_start = '0;
    logic [LW-1:0]     first_end = '0;
    logic [LW-1:0]     second_start = '0;
    logic [LW-1:0]     second_end = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [HASH_W-1:0] hash_value;
    logic              ranges_equal;
    logic [LW-1:0]     string_length;
    logic [1:0]        status;

    hash_scoreboard sb;
    bit             squeeze_req = 1'b0;
    int             cycles = 0;

    substring_rolling_hash_engine_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .char_byte(char_byte),
        .first_start(first_start), .first_end(first_end),
        .second_start(second_start), .second_end(second_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .hash_value(hash_value), .ranges_equal(ranges_equal),
        .string_length(string_length), .status(status)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_word(hash_value, ranges_equal, string_length, status);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_left = 400;
                out_stall <= 1'b1;
            end
            else if (!out_stall && $urandom_range(0, 3) == 0)
            begin
                hold_left = pick_gap();
                out_stall <= hold_left > 0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send(mode_t m, logic [7:0] b, int l1, int r1, int l2, int r2);
        int gap;
        in_valid <= 1'b1;
        mode <= m;
        char_byte <= b;
        first_start <= LW'(l1);
        first_end <= LW'(r1);
        second_start <= LW'(l2);
        second_end <= LW'(r2);
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(m, b, l1, r1, l2, r2);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic set_base(logic [HASH_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.base = v;
    endtask

    task automatic rand_append();
        logic [7:0] b;
        b = ($urandom_range(0, 1)) ? 8'($urandom_range(97, 99)) : 8'($urandom);
        send(MODE_APPEND, b, $urandom_range(0, 8191), $urandom_range(0, 8191),
             $urandom_range(0, 8191), $urandom_range(0, 8191));
    endtask

    task automatic rand_query();
        int n, l1, r1, l2, w;
        n = sb.cur_len;
        if ($urandom_range(0, 9) == 0)
        begin
            send($urandom_range(0, 1) ? MODE_HASH : MODE_CMP, 8'($urandom),
                 $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191), $urandom_range(0, n + 2));
            return;
        end
        w = $urandom_range(0, n < 8 ? n : 8);
        l1 = $urandom_range(0, n - w);
        r1 = l1 + w;
        l2 = $urandom_range(0, n - w);
        send($urandom_range(0, 1) ? MODE_HASH : MODE_CMP, 8'($urandom),
             l1, r1, l2, l2 + w);
    endtask

    task automatic random_phase(int count);
        int k;
        send(MODE_CLEAR, 8'($urandom), 0, 0, 0, 0);
        for (k = 0; k < count; k++)
        begin
            if (sb.cur_len < 4 || $urandom_range(0, 2) == 0)
                rand_append();
            else if ($urandom_range(0, 40) == 0)
                send(MODE_CLEAR, 8'($urandom), $urandom_range(0, 8191), 0, 0, 0);
            else
                rand_query();
        end
    endtask

    initial
    begin : stimulus
        logic [HASH_W-1:0] b;
        int k;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(MODE_HASH, 8'h00, 0, 0, 0, 0);
        send(MODE_CLEAR, 8'hff, 8191, 8191, 8191, 8191);
        send(MODE_APPEND, 8'h00, 0, 0, 0, 0);
        send(MODE_APPEND, 8'hff, 8191, 8191, 8191, 8191);
        send(MODE_APPEND, 8'h61, 0, 0, 0, 0);
        send(MODE_APPEND, 8'h62, 0, 0, 0, 0);
        send(MODE_APPEND, 8'h61, 0, 0, 0, 0);
        send(MODE_APPEND, 8'h62, 0, 0, 0, 0);
        send(MODE_HASH, 8'h00, 0, 6, 0, 0);
        send(MODE_HASH, 8'h00, 3, 3, 0, 0);
        send(MODE_CMP, 8'h00, 2, 4, 4, 6);
        send(MODE_CMP, 8'h00, 1, 3, 2, 4);
        send(MODE_HASH, 8'h00, 4, 3, 0, 0);
        send(MODE_HASH, 8'h00, 0, 7, 0, 0);
        send(MODE_CMP, 8'h00, 0, 2, 5, 4);
        send(MODE_CMP, 8'h00, 0, 2, 0, 8191);
        send(MODE_HASH, 8'hff, 8191, 8191, 8191, 8191);
        send(MODE_CLEAR, 8'h00, 0, 0, 0, 0);
        send(MODE_HASH, 8'h00, 0, 0, 0, 0);
        send(MODE_HASH, 8'h00, 0, 1, 0, 0);
        send(MODE_APPEND, 8'h80, 0, 0, 0, 0);
        send(MODE_CMP, 8'h00, 0, 1, 0, 1);

        set_base(61'd2);
        random_phase(60);
        set_base(HASH_MOD - 61'd1);
        squeeze_req = 1'b1;
        random_phase(250);
        for (k = 0; k < 3; k++)
        begin
            do
                b = HASH_W'({$urandom, $urandom});
            while (b < 2 || b >= HASH_MOD);
            set_base(b);
            random_phase(180);
        end
        set_base(BASE_RST);
        random_phase(100);

        send(MODE_CLEAR, 8'h00, 0, 0, 0, 0);
        in_valid <= 1'b0;

        drain();
        if (sb.pending.size() != 0)
            sb.errors++;
        $display("checked %0d result words: %0d capacity full, %0d bad ranges, %0d equal pairs",
                 sb.checked, sb.n_full, sb.n_bad, sb.n_equal);
        $display("six bases including the extremes, one long output hold");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/srh_pkg.sv
rtl/core/srh_ram.sv
rtl/core/srh_mulmod.sv
rtl/core/srh_datapath.sv
rtl/core/srh_ctrl.sv
rtl/core/substring_rolling_hash_engine_core.sv
rtl/core/srh_checker.sv
test/substring_rolling_hash_engine_core_tb.sv
